/* rtl/csi_pkg.sv */
package csi_pkg;

	// Position and depth widths.
	localparam int unsigned POS_BITS   = 31;
	localparam int unsigned DEPTH_BITS = 16;

	// Derived widths: run start reaches one past the largest position.
	localparam int unsigned RS_W   = POS_BITS + 1;
	localparam int unsigned PROD_W = RS_W + DEPTH_BITS;
	localparam int unsigned TOT_W  = 64;

	// Port field widths.
	localparam int unsigned EVT_POS_W = 31;
	localparam int unsigned ISTART_W  = 32;
	localparam int unsigned IEND_W    = 31;
	localparam int unsigned DEPTH_W   = 16;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_INTERVAL = 2'd0,
		KIND_TOTAL    = 2'd1,
		KIND_ERROR    = 2'd2
	} kind_t;

	// One result beat as held in the output queue.
	typedef struct packed {
		kind_t                kind;
		logic [ISTART_W-1:0]  interval_start;
		logic [IEND_W-1:0]    interval_end;
		logic [DEPTH_W-1:0]   depth;
		logic [TOT_W-1:0]     cov_total;
		logic                 last;
	} res_t;

endpackage

/* rtl/csi_if.sv */
// Endpoint event channel.
interface csi_evt_if;
	logic                           valid;
	logic                           ready;
	logic [csi_pkg::EVT_POS_W-1:0]  event_pos;
	logic                           is_end;
	logic                           first_event;
	logic                           last_event;

	modport source (output valid, event_pos, is_end, first_event, last_event, input ready);
	modport sink (input valid, event_pos, is_end, first_event, last_event, output ready);
endinterface

// Result channel.
interface csi_res_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     kind;
	logic [csi_pkg::ISTART_W-1:0]   interval_start;
	logic [csi_pkg::IEND_W-1:0]     interval_end;
	logic [csi_pkg::DEPTH_W-1:0]    depth;
	logic [csi_pkg::TOT_W-1:0]      cov_total;
	logic                           last;

	modport source (output valid, kind, interval_start, interval_end, depth, cov_total,
		last, input ready);
	modport sink (input valid, kind, interval_start, interval_end, depth, cov_total,
		last, output ready);
endinterface

/* rtl/coverage_sweep_intervals.sv */
// An accepted beat moves through stages 1, 2 and 3; its results then enter the result queue.
// Throughput: one event per cycle; the result port moves one beat per cycle, so an event
// that yields two results (interval plus total or error) takes two beats on the result port.
// The input stalls only when the four-entry result queue cannot take two more beats.
// Reset: run start returns to one, depth, total and error flag clear, pipeline and queue
// empty; the block takes events in the first cycle after reset.
module coverage_sweep_intervals (
	input  logic          clk,
	input  logic          arst_n,
	csi_evt_if.sink       evt,
	csi_res_if.source     res
);
	import csi_pkg::*;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW    = Q_AW + 1;

	// Sweep state.
	logic [RS_W-1:0]       rs_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic                  err_q;
	logic [TOT_W-1:0]      total_q;

	// Stage 1: registered input beat.
	logic                  valid_s1;
	logic [POS_BITS-1:0]   pos_s1;
	logic                  is_end_s1;
	logic                  first_s1;
	logic                  last_s1;

	// Stage 2: interval found, state moved.
	logic                  valid_s2;
	logic                  iv_s2;
	logic [RS_W-1:0]       start_s2;
	logic [POS_BITS-1:0]   end_s2;
	logic [DEPTH_BITS-1:0] dep_s2;
	logic [RS_W-1:0]       len_s2;
	logic                  err_s2;
	logic                  tot_s2;
	logic                  first_s2;

	// Stage 3: product of length and depth.
	logic                  valid_s3;
	logic                  iv_s3;
	logic [RS_W-1:0]       start_s3;
	logic [POS_BITS-1:0]   end_s3;
	logic [DEPTH_BITS-1:0] dep_s3;
	logic [PROD_W-1:0]     prod_s3;
	logic                  err_s3;
	logic                  tot_s3;
	logic                  first_s3;

	// Result queue.
	res_t                  mem_q [Q_DEPTH];
	logic [Q_AW-1:0]       wr_q;
	logic [Q_AW-1:0]       rd_q;
	logic [Q_CW-1:0]       cnt_q;

	logic                  adv;
	logic                  pop;

	// The whole pipeline moves when the queue has room for two beats.
	assign adv       = (cnt_q <= Q_CW'(Q_DEPTH - 2));
	assign evt.ready = adv;
	assign pop       = res.valid && res.ready;

	// Stage 1 input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1    <= evt.event_pos[POS_BITS-1:0];
			is_end_s1 <= evt.is_end;
			first_s1  <= evt.first_event;
			last_s1   <= evt.last_event;
		end
	end

	// Sweep step: pending interval and next run start and depth.
	logic [RS_W-1:0]       rs_c;
	logic [DEPTH_BITS-1:0] dep_c;
	logic                  err_c;
	logic [RS_W-1:0]       posx;
	logic                  iv_c;
	logic [RS_W-1:0]       iv_end_c;
	logic [RS_W-1:0]       len_c;
	logic [RS_W-1:0]       rs_n;
	logic [DEPTH_BITS-1:0] dep_n;
	logic                  err_n;
	logic                  proc_c;

	always_comb begin
		rs_c   = first_s1 ? RS_W'(1) : rs_q;
		dep_c  = first_s1 ? '0 : depth_q;
		err_c  = first_s1 ? 1'b0 : err_q;
		proc_c = valid_s1 && !err_c;
		posx   = RS_W'(pos_s1);
		if (is_end_s1) begin
			iv_c     = (posx >= rs_c);
			iv_end_c = posx;
			rs_n     = posx + RS_W'(1);
			err_n    = (dep_c == '0);
			dep_n    = err_n ? dep_c : dep_c - DEPTH_BITS'(1);
		end else begin
			iv_c     = (posx > rs_c);
			iv_end_c = posx - RS_W'(1);
			rs_n     = posx;
			err_n    = (dep_c == '1);
			dep_n    = err_n ? dep_c : dep_c + DEPTH_BITS'(1);
		end
		len_c = iv_end_c - rs_c + RS_W'(1);
	end

	// State registers and the stage 2 and stage 3 valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q     <= RS_W'(1);
			depth_q  <= '0;
			err_q    <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= proc_c;
			valid_s3 <= valid_s2;
			if (proc_c) begin
				rs_q    <= rs_n;
				depth_q <= dep_n;
				err_q   <= err_n;
			end
		end
	end

	// Stage 2 and stage 3 payload; the multiply sits alone in stage 3.
	always_ff @(posedge clk) begin
		if (adv) begin
			iv_s2    <= iv_c;
			start_s2 <= rs_c;
			end_s2   <= iv_end_c[POS_BITS-1:0];
			dep_s2   <= dep_c;
			len_s2   <= len_c;
			err_s2   <= err_n;
			tot_s2   <= !err_n && last_s1;
			first_s2 <= first_s1;

			iv_s3    <= iv_s2;
			start_s3 <= start_s2;
			end_s3   <= end_s2;
			dep_s3   <= dep_s2;
			prod_s3  <= PROD_W'(len_s2) * PROD_W'(dep_s2);
			err_s3   <= err_s2;
			tot_s3   <= tot_s2;
			first_s3 <= first_s2;
		end
	end

	// Saturating accumulation of the running total.
	logic [TOT_W-1:0] base_c;
	logic [TOT_W:0]   sum_c;
	logic [TOT_W-1:0] total_n;

	always_comb begin
		base_c  = first_s3 ? '0 : total_q;
		sum_c   = {1'b0, base_c} + (iv_s3 ? (TOT_W + 1)'(prod_s3) : '0);
		total_n = sum_c[TOT_W] ? '1 : sum_c[TOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (adv && valid_s3) begin
			total_q <= total_n;
		end
	end

	// Result beats for this event: interval first, then total or error.
	res_t            ent_iv;
	res_t            ent_2;
	res_t            ent0;
	logic            has2;
	logic [1:0]      npush;

	always_comb begin
		has2                  = err_s3 || tot_s3;
		ent_iv.kind           = KIND_INTERVAL;
		ent_iv.interval_start = ISTART_W'(start_s3);
		ent_iv.interval_end   = IEND_W'(end_s3);
		ent_iv.depth          = DEPTH_W'(dep_s3);
		ent_iv.cov_total      = '0;
		ent_iv.last           = !has2;
		ent_2.kind            = err_s3 ? KIND_ERROR : KIND_TOTAL;
		ent_2.interval_start  = '0;
		ent_2.interval_end    = '0;
		ent_2.depth           = '0;
		ent_2.cov_total       = err_s3 ? '0 : total_n;
		ent_2.last            = 1'b1;
		ent0                  = iv_s3 ? ent_iv : ent_2;
		if (adv && valid_s3) begin
			npush = 2'(iv_s3) + 2'(has2);
		end else begin
			npush = 2'd0;
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (npush != 2'd0) begin
			mem_q[wr_q] <= ent0;
		end
		if (npush == 2'd2) begin
			mem_q[wr_q + Q_AW'(1)] <= ent_2;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + Q_AW'(npush);
			rd_q  <= rd_q + Q_AW'(pop);
			cnt_q <= cnt_q + Q_CW'(npush) - Q_CW'(pop);
		end
	end

	// Result port.
	assign res.valid          = (cnt_q != '0);
	assign res.kind           = mem_q[rd_q].kind;
	assign res.interval_start = mem_q[rd_q].interval_start;
	assign res.interval_end   = mem_q[rd_q].interval_end;
	assign res.depth          = mem_q[rd_q].depth;
	assign res.cov_total      = mem_q[rd_q].cov_total;
	assign res.last           = mem_q[rd_q].last;

	// The queue never holds more beats than it has entries.
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CW'(Q_DEPTH))
		else $error("result queue overfilled");

	// A latched error freezes the sweep until a first event arrives.
	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && !(adv && valid_s1 && first_s1) |=> $stable(rs_q) && $stable(depth_q))
		else $error("sweep state moved while error latched");

	// Emitted intervals are never empty.
	a_iv_order: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == KIND_INTERVAL |->
		res.interval_start <= ISTART_W'(res.interval_end))
		else $error("empty interval emitted");

	// Totals and errors always close an event's results.
	a_tail_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind != KIND_INTERVAL |-> res.last)
		else $error("total or error beat not marked last");

endmodule

/* sim/coverage_sweep_intervals_test.sv */
module coverage_sweep_intervals_test;
	timeunit 1ns;
	timeprecision 1ps;

	import csi_pkg::*;

	// One endpoint event as offered on the input channel.
	typedef struct packed {
		logic [EVT_POS_W-1:0] pos;
		logic                 is_end;
		logic                 first_event;
		logic                 last_event;
	} ev_t;

	// A directed row: the event and, where typed in, its results (n < 0 means predicted).
	typedef struct {
		ev_t  ev;
		int   n;
		res_t r0;
		res_t r1;
	} stim_row_t;

	localparam logic [DEPTH_BITS:0] DEPTH_FULL = (DEPTH_BITS + 1)'((1 << DEPTH_BITS) - 1);
	localparam logic [EVT_POS_W-1:0] POS_TOP = '1;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	csi_evt_if evt_ch();
	csi_res_if res_ch();

	coverage_sweep_intervals dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sweep state mirrored by the predictor.
	logic [32:0]         sweep_start;
	logic [DEPTH_BITS:0] sweep_depth;
	logic [63:0]         sweep_total;
	bit                  sweep_err;

	res_t        step_beats[$];
	res_t        pending_beats[$];
	stim_row_t   stim_rows[$];
	int unsigned send_gap_pct;
	int unsigned recv_gap_pct;
	int          swept_events;
	int          fail_count;
	bit          long_hold_req;

	function automatic res_t beat_iv(logic [31:0] s, logic [30:0] e, logic [15:0] d, bit lst);
		res_t r;
		r = '0;
		r.kind = KIND_INTERVAL;
		r.interval_start = s;
		r.interval_end = e;
		r.depth = d;
		r.last = lst;
		return r;
	endfunction

	function automatic res_t beat_tot(logic [63:0] t);
		res_t r;
		r = '0;
		r.kind = KIND_TOTAL;
		r.cov_total = t;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic res_t beat_err();
		res_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.last = 1'b1;
		return r;
	endfunction

	// Sweep one event: fills step_beats, returns 0 when the event is ignored.
	function automatic bit sweep_predict(ev_t e);
		logic [32:0] p;
		logic [32:0] iv_end;
		logic [63:0] prod;
		logic [64:0] sum;
		bit          has_iv;
		step_beats.delete();
		p = {2'b00, e.pos};
		if (e.first_event) begin
			sweep_start = 33'd1;
			sweep_depth = '0;
			sweep_total = '0;
			sweep_err = 1'b0;
		end
		if (sweep_err)
			return 1'b0;

		// An end closes the run at its position, a start just before it.
		if (e.is_end) begin
			has_iv = p >= sweep_start;
			iv_end = p;
		end else begin
			has_iv = p > sweep_start;
			iv_end = p - 33'd1;
		end
		if (has_iv) begin
			step_beats.push_back(beat_iv(sweep_start[31:0], iv_end[30:0],
				sweep_depth[15:0], 1'b0));
			prod = 64'(iv_end - sweep_start + 33'd1) * 64'(sweep_depth);
			sum = {1'b0, sweep_total} + {1'b0, prod};
			sweep_total = sum[64] ? '1 : sum[63:0];
		end

		// Move the run start and the depth; underflow and overflow latch an error.
		if (e.is_end) begin
			sweep_start = p + 33'd1;
			if (sweep_depth == '0)
				sweep_err = 1'b1;
			else
				sweep_depth = sweep_depth - (DEPTH_BITS + 1)'(1);
		end else begin
			sweep_start = p;
			if (sweep_depth >= DEPTH_FULL)
				sweep_err = 1'b1;
			else
				sweep_depth = sweep_depth + (DEPTH_BITS + 1)'(1);
		end

		if (sweep_err)
			step_beats.push_back(beat_err());
		else if (e.last_event)
			step_beats.push_back(beat_tot(sweep_total));
		if (step_beats.size() > 0)
			step_beats[step_beats.size()-1].last = 1'b1;
		return 1'b1;
	endfunction

	function automatic void put_row(logic [30:0] pos, bit is_end, bit fst, bit lst, int n,
		res_t r0, res_t r1);
		stim_row_t row;
		row.ev = '{pos, is_end, fst, lst};
		row.n = n;
		row.r0 = r0;
		row.r1 = r1;
		stim_rows.push_back(row);
	endfunction

	// Offer one event and return at the edge that accepts it.
	task automatic drive_beat(ev_t e);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			evt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.event_pos <= e.pos;
		evt_ch.is_end <= e.is_end;
		evt_ch.first_event <= e.first_event;
		evt_ch.last_event <= e.last_event;
		@(negedge clk);
		while (!evt_ch.ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_swept(ev_t e);
		drive_beat(e);
		if (sweep_predict(e))
			swept_events++;
		foreach (step_beats[i])
			pending_beats.push_back(step_beats[i]);
	endtask

	// A well-formed sorted sequence, with now and then an underflow or a step back.
	task automatic send_sequence();
		int          n_ev;
		int          lvl;
		bit          opened;
		bit          closing;
		logic [31:0] nxt;
		logic [30:0] pos;
		ev_t         e;
		n_ev = $urandom_range(2, 24);
		lvl = 0;
		opened = $urandom_range(0, 9) != 0;
		pos = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 64));
		for (int i = 0; i < n_ev; i++) begin
			closing = i == n_ev - 1;
			if (closing)
				e.is_end = lvl > 0;
			else if (lvl == 0)
				e.is_end = $urandom_range(0, 29) == 0;
			else
				e.is_end = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0: nxt = {1'b0, pos};
				8: nxt = {1'b0, pos} + $urandom_range(0, 1 << 16);
				9: begin
					if ($urandom_range(0, 4) == 0)
						nxt = {1'b0, pos} - $urandom_range(0, 32);
					else
						nxt = {1'b0, pos} + $urandom_range(0, 1 << 24);
				end
				default: nxt = {1'b0, pos} + $urandom_range(1, 16);
			endcase
			pos = nxt[31] ? POS_TOP : nxt[30:0];
			e.pos = pos;
			e.first_event = (i == 0) && opened;
			e.last_event = closing;
			send_swept(e);
			lvl = e.is_end ? ((lvl > 0) ? lvl - 1 : 0) : lvl + 1;
		end
	endtask

	task automatic send_random(int target);
		int   stop_at;
		ev_t  e;
		stop_at = swept_events + target;
		while (swept_events < stop_at) begin
			if ($urandom_range(0, 99) < 85) begin
				send_sequence();
			end else begin
				repeat ($urandom_range(1, 3)) begin
					e.pos = 31'($urandom);
					e.is_end = 1'($urandom_range(0, 1));
					e.first_event = $urandom_range(0, 9) < 3;
					e.last_event = 1'($urandom_range(0, 1));
					send_swept(e);
				end
			end
		end
	endtask

	task automatic drain_results();
		evt_ch.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Receiver: random ready, or a long hold-off when one is requested.
	initial begin
		int hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= $urandom_range(0, 99) >= recv_gap_pct;
			end
		end
	end

	// Compare every accepted result beat with the oldest expectation.
	always @(negedge clk) begin
		res_t exp_beat;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_beats.size() == 0) begin
				fail_count++;
				$error("result beat with nothing expected: kind %0d", res_ch.kind);
			end else begin
				exp_beat = pending_beats.pop_front();
				if (res_ch.kind !== exp_beat.kind) begin
					fail_count++;
					$error("kind: expected %0d, got %0d", exp_beat.kind, res_ch.kind);
				end
				if (res_ch.interval_start !== exp_beat.interval_start) begin
					fail_count++;
					$error("interval_start: expected %0d, got %0d",
						exp_beat.interval_start, res_ch.interval_start);
				end
				if (res_ch.interval_end !== exp_beat.interval_end) begin
					fail_count++;
					$error("interval_end: expected %0d, got %0d",
						exp_beat.interval_end, res_ch.interval_end);
				end
				if (res_ch.depth !== exp_beat.depth) begin
					fail_count++;
					$error("depth: expected %0d, got %0d", exp_beat.depth, res_ch.depth);
				end
				if (res_ch.cov_total !== exp_beat.cov_total) begin
					fail_count++;
					$error("cov_total: expected %0d, got %0d",
						exp_beat.cov_total, res_ch.cov_total);
				end
				if (res_ch.last !== exp_beat.last) begin
					fail_count++;
					$error("last: expected %0d, got %0d", exp_beat.last, res_ch.last);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.event_pos = '0;
		evt_ch.is_end = 1'b0;
		evt_ch.first_event = 1'b0;
		evt_ch.last_event = 1'b0;
		send_gap_pct = 22;
		recv_gap_pct = 70;
		swept_events = 0;
		fail_count = 0;
		long_hold_req = 1'b0;
		sweep_start = 33'd1;
		sweep_depth = '0;
		sweep_total = '0;
		sweep_err = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: pos, is_end, first, last, typed result count, results.
		put_row(31'd1, 0, 1, 0, 0, '0, '0);
		put_row(31'd1, 0, 0, 0, 0, '0, '0);
		put_row(31'd10, 1, 0, 0, 1, beat_iv(32'd1, 31'd10, 16'd2, 1'b1), '0);
		put_row(31'd10, 1, 0, 1, 1, beat_tot(64'd20), '0);
		// Underflow: the pending interval, then an error.
		put_row(31'd20, 1, 0, 0, 2, beat_iv(32'd11, 31'd20, 16'd0, 1'b0), beat_err());
		// While the error is latched the event is ignored.
		put_row(31'd30, 0, 0, 1, 0, '0, '0);
		// Position zero and the largest position.
		put_row(31'd0, 0, 1, 0, 0, '0, '0);
		put_row(POS_TOP, 1, 0, 0, 1, beat_iv(32'd0, POS_TOP, 16'd1, 1'b1), '0);
		put_row(POS_TOP, 0, 0, 1, 1, beat_tot(64'h8000_0000), '0);
		put_row(POS_TOP, 1, 0, 1, -1, '0, '0);
		put_row(31'd0, 0, 0, 0, -1, '0, '0);
		put_row(31'd5, 1, 1, 1, 2, beat_iv(32'd1, 31'd5, 16'd0, 1'b0), beat_err());
		put_row(31'd100, 0, 1, 0, 1, beat_iv(32'd1, 31'd99, 16'd0, 1'b1), '0);
		put_row(31'h5555_5555, 0, 0, 0, -1, '0, '0);
		// Unsorted end below the run start.
		put_row(31'h2AAA_AAAA, 1, 0, 0, -1, '0, '0);
		put_row(31'h2AAA_AAAC, 0, 0, 0, -1, '0, '0);
		put_row(31'h2AAA_AAAC, 1, 0, 1, -1, '0, '0);
		put_row(31'd3, 0, 1, 0, -1, '0, '0);
		put_row(31'd3, 0, 0, 0, -1, '0, '0);
		put_row(31'd3, 1, 0, 1, -1, '0, '0);
		// The sweep goes on past a last event when no first event follows.
		put_row(31'd4, 1, 0, 0, -1, '0, '0);
		put_row(31'd9, 0, 1, 1, 2, beat_iv(32'd1, 31'd8, 16'd0, 1'b0), beat_tot(64'd0));

		foreach (stim_rows[i]) begin
			drive_beat(stim_rows[i].ev);
			void'(sweep_predict(stim_rows[i].ev));
			if (stim_rows[i].n < 0) begin
				foreach (step_beats[j])
					pending_beats.push_back(step_beats[j]);
			end else begin
				if (stim_rows[i].n > 0)
					pending_beats.push_back(stim_rows[i].r0);
				if (stim_rows[i].n > 1)
					pending_beats.push_back(stim_rows[i].r1);
			end
		end

		// Receiver holds off while the sender keeps offering, then the sender waits out.
		long_hold_req = 1'b1;
		send_gap_pct = 0;
		send_random(60);
		drain_results();

		send_gap_pct = 22;
		send_random(300);

		send_gap_pct = 70;
		recv_gap_pct = 22;
		send_random(320);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		send_random(320);

		drain_results();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
